[rtl/swte_pkg.sv]
`default_nettype none

package swte_pkg;

    localparam logic [31:0] PROTO_MAGIC    = 32'h4253_4852;
    localparam logic [10:0] HEADER_BYTES   = 11'd12;
    localparam logic [22:0] CHUNK_BYTES    = 23'd1024;
    localparam logic [22:0] MAX_FILE_RESET = 23'd4194304;

    localparam logic [7:0] K_DISC   = 8'd1;
    localparam logic [7:0] K_ANN    = 8'd2;
    localparam logic [7:0] K_OFFER  = 8'd3;
    localparam logic [7:0] K_ACCEPT = 8'd4;
    localparam logic [7:0] K_DATA   = 8'd5;
    localparam logic [7:0] K_ACK    = 8'd6;
    localparam logic [7:0] K_DONE   = 8'd7;

    localparam logic [2:0] RK_ANN    = 3'd2;
    localparam logic [2:0] RK_ACCEPT = 3'd4;
    localparam logic [2:0] RK_ACK    = 3'd6;

    localparam logic ROLE_SENDER   = 1'b0;
    localparam logic ROLE_RECEIVER = 1'b1;

    localparam logic REG_ROLE_MODE      = 1'b0;
    localparam logic REG_MAX_FILE_BYTES = 1'b1;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } ctrl_sts_t;

endpackage

`default_nettype wire

[rtl/swte_ctrl.sv]
`default_nettype none

module swte_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    output swte_pkg::ctrl_cmd_t  cmd,
    input  swte_pkg::ctrl_sts_t  sts
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.scan   = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_done) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[rtl/swte_dp.sv]
`default_nettype none

module swte_dp #(
    parameter int PEER_SLOTS = 16
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  swte_pkg::ctrl_cmd_t  cmd,
    output swte_pkg::ctrl_sts_t  sts,
    input  wire                  cfg_wr_en,
    input  wire                  cfg_index,
    input  wire  [22:0]          cfg_wr_data,
    input  wire  [31:0]          s_source_addr,
    input  wire  [31:0]          s_magic_word,
    input  wire  [7:0]           s_packet_kind,
    input  wire  [15:0]          s_seq_number,
    input  wire  [31:0]          s_header_arg,
    input  wire  [10:0]          s_total_length,
    output logic                 m_valid,
    input  wire                  m_ready,
    output logic                 m_reply_valid,
    output logic [2:0]           m_reply_kind,
    output logic [31:0]          m_reply_addr,
    output logic [15:0]          m_reply_seq,
    output logic                 m_reply_arg,
    output logic                 m_store_valid,
    output logic [22:0]          m_store_offset,
    output logic [10:0]          m_store_len,
    output logic                 m_transfer_done,
    output logic                 m_accept_seen,
    output logic [15:0]          m_last_acked_seq
);

    localparam int CNT_W = $clog2(PEER_SLOTS + 1);
    localparam int IDX_W = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;

    // configuration
    logic        role_reg;
    logic [22:0] max_bytes_reg;

    // latched item
    logic [31:0] src_reg;
    logic [31:0] magic_reg;
    logic [7:0]  kind_reg;
    logic [15:0] seq_reg;
    logic [31:0] arg_reg;
    logic [10:0] len_reg;

    // endpoint state
    logic        busy_reg,      busy_next;
    logic [31:0] bound_reg,     bound_next;
    logic [22:0] fsize_reg,     fsize_next;
    logic [22:0] brecv_reg,     brecv_next;
    logic [15:0] exp_seq_reg,   exp_seq_next;
    logic        done_reg,      done_next;
    logic [CNT_W-1:0] count_reg;
    logic        accept_reg,    accept_next;
    logic [15:0] last_ack_reg,  last_ack_next;

    // peer table and scan
    logic [31:0]      peer_mem [PEER_SLOTS];
    logic [31:0]      rd_data_reg;
    logic [CNT_W-1:0] scan_idx_reg;
    logic             cmp_pend_reg;
    logic             known_reg;
    logic             peer_we;

    // result
    logic        m_valid_reg;
    logic        r_valid, r_arg, st_valid;
    logic [2:0]  r_kind;
    logic [31:0] r_addr;
    logic [15:0] r_seq;
    logic [22:0] st_off;
    logic [10:0] st_len;

    logic        hdr_ok;
    logic        from_bound;
    logic        need_scan;
    logic        table_open;
    logic [10:0] pay;
    logic [22:0] room;
    logic [22:0] take;

    assign hdr_ok     = (len_reg >= swte_pkg::HEADER_BYTES) && (magic_reg == swte_pkg::PROTO_MAGIC);
    assign from_bound = busy_reg && (src_reg == bound_reg);
    assign need_scan  = hdr_ok && (role_reg == swte_pkg::ROLE_SENDER)
                        && (kind_reg == swte_pkg::K_ANN);
    assign table_open = (count_reg < CNT_W'(PEER_SLOTS));
    assign pay        = len_reg - swte_pkg::HEADER_BYTES;
    assign room       = (fsize_reg >= brecv_reg) ? (fsize_reg - brecv_reg) : 23'd0;

    always_comb begin
        take = ({12'd0, pay} < room) ? {12'd0, pay} : room;
        if (take > swte_pkg::CHUNK_BYTES) begin
            take = swte_pkg::CHUNK_BYTES;
        end
    end

    assign sts.scan_done = !need_scan || ((scan_idx_reg == count_reg) && !cmp_pend_reg);
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign peer_we = cmd.commit && need_scan && !known_reg && table_open;

    always_comb begin
        busy_next     = busy_reg;
        bound_next    = bound_reg;
        fsize_next    = fsize_reg;
        brecv_next    = brecv_reg;
        exp_seq_next  = exp_seq_reg;
        done_next     = done_reg;
        accept_next   = accept_reg;
        last_ack_next = last_ack_reg;
        r_valid  = 1'b0;
        r_kind   = 3'd0;
        r_addr   = 32'd0;
        r_seq    = 16'd0;
        r_arg    = 1'b0;
        st_valid = 1'b0;
        st_off   = 23'd0;
        st_len   = 11'd0;
        if (hdr_ok) begin
            if (role_reg == swte_pkg::ROLE_RECEIVER) begin
                case (kind_reg)
                    swte_pkg::K_DISC: begin
                        r_valid = 1'b1;
                        r_kind  = swte_pkg::RK_ANN;
                        r_addr  = src_reg;
                    end
                    swte_pkg::K_OFFER: begin
                        if ((!busy_reg || from_bound) && (arg_reg <= {9'd0, max_bytes_reg})) begin
                            if (!busy_reg) begin
                                fsize_next   = arg_reg[22:0];
                                brecv_next   = 23'd0;
                                exp_seq_next = 16'd0;
                                bound_next   = src_reg;
                                busy_next    = 1'b1;
                            end
                            r_valid = 1'b1;
                            r_kind  = swte_pkg::RK_ACCEPT;
                            r_addr  = src_reg;
                        end
                    end
                    swte_pkg::K_DATA: begin
                        if (from_bound) begin
                            if (seq_reg == exp_seq_reg) begin
                                if (take != 23'd0) begin
                                    st_valid = 1'b1;
                                    st_off   = brecv_reg;
                                    st_len   = take[10:0];
                                end
                                brecv_next   = brecv_reg + take;
                                exp_seq_next = exp_seq_reg + 16'd1;
                            end
                            r_valid = 1'b1;
                            r_kind  = swte_pkg::RK_ACK;
                            r_addr  = src_reg;
                            r_seq   = seq_reg;
                        end
                    end
                    swte_pkg::K_DONE: begin
                        if (from_bound) begin
                            r_valid   = 1'b1;
                            r_kind    = swte_pkg::RK_ACK;
                            r_addr    = src_reg;
                            r_seq     = seq_reg;
                            r_arg     = 1'b1;
                            done_next = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end else begin
                case (kind_reg)
                    swte_pkg::K_ACCEPT: accept_next   = 1'b1;
                    swte_pkg::K_ACK:    last_ack_next = seq_reg;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (peer_we) begin
            peer_mem[count_reg[IDX_W-1:0]] <= src_reg;
        end
        rd_data_reg <= peer_mem[scan_idx_reg[IDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            src_reg   <= s_source_addr;
            magic_reg <= s_magic_word;
            kind_reg  <= s_packet_kind;
            seq_reg   <= s_seq_number;
            arg_reg   <= s_header_arg;
            len_reg   <= s_total_length;
        end
        if (cmd.commit) begin
            m_reply_valid    <= r_valid;
            m_reply_kind     <= r_kind;
            m_reply_addr     <= r_addr;
            m_reply_seq      <= r_seq;
            m_reply_arg      <= r_arg;
            m_store_valid    <= st_valid;
            m_store_offset   <= st_off;
            m_store_len      <= st_len;
            m_transfer_done  <= done_next;
            m_accept_seen    <= accept_next;
            m_last_acked_seq <= last_ack_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            role_reg      <= swte_pkg::ROLE_SENDER;
            max_bytes_reg <= swte_pkg::MAX_FILE_RESET;
            busy_reg      <= 1'b0;
            bound_reg     <= 32'd0;
            fsize_reg     <= 23'd0;
            brecv_reg     <= 23'd0;
            exp_seq_reg   <= 16'd0;
            done_reg      <= 1'b0;
            count_reg     <= '0;
            accept_reg    <= 1'b0;
            last_ack_reg  <= 16'd0;
            scan_idx_reg  <= '0;
            cmp_pend_reg  <= 1'b0;
            known_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    swte_pkg::REG_ROLE_MODE:      role_reg      <= cfg_wr_data[0];
                    swte_pkg::REG_MAX_FILE_BYTES: max_bytes_reg <= cfg_wr_data;
                    default: begin
                    end
                endcase
            end

            if (cmd.load) begin
                scan_idx_reg <= '0;
                cmp_pend_reg <= 1'b0;
                known_reg    <= 1'b0;
            end else if (cmd.scan && need_scan) begin
                // one read issued per cycle, compared the cycle after
                if (scan_idx_reg != count_reg) begin
                    scan_idx_reg <= scan_idx_reg + CNT_W'(1);
                    cmp_pend_reg <= 1'b1;
                end else begin
                    cmp_pend_reg <= 1'b0;
                end
                if (cmp_pend_reg && (rd_data_reg == src_reg)) begin
                    known_reg <= 1'b1;
                end
            end

            if (cmd.commit) begin
                busy_reg     <= busy_next;
                bound_reg    <= bound_next;
                fsize_reg    <= fsize_next;
                brecv_reg    <= brecv_next;
                exp_seq_reg  <= exp_seq_next;
                done_reg     <= done_next;
                accept_reg   <= accept_next;
                last_ack_reg <= last_ack_next;
                if (peer_we) begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end

            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

[rtl/stop_wait_transfer_endpoint_core.sv]
// Stop-and-wait file-transfer endpoint.
// Input channel (s_valid/s_ready): one decoded packet header per item.
// Output channel (m_valid/m_ready): exactly one result item per input item,
// carrying the reply to send, the buffer write (offset, length) for data, and
// the done/accept/last-ack status after that packet.
// Configuration: cfg_wr_en/cfg_index/cfg_wr_data, index 0 role_mode,
// index 1 max_file_bytes; write only while no item is in flight.
// An accepted item is latched, passes the scan and commit states, and its
// result is registered. An announce in sender role scans the peer table, one
// entry per cycle from a registered memory read. No new item is taken until
// the current one has been committed.
// The result sits in an output register; the next item is taken and worked
// on while it waits, and only the final write of a result stalls on m_ready.
// Reset (aresetn, synchronous, active low) clears the endpoint state, the
// peer count and the output valid; the peer table itself needs no clearing.
`default_nettype none

module stop_wait_transfer_endpoint_core #(
    parameter int PEER_SLOTS = 16
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_wr_en,
    input  wire         cfg_index,
    input  wire  [22:0] cfg_wr_data,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [31:0] s_source_addr,
    input  wire  [31:0] s_magic_word,
    input  wire  [7:0]  s_packet_kind,
    input  wire  [15:0] s_seq_number,
    input  wire  [31:0] s_header_arg,
    input  wire  [10:0] s_total_length,
    output logic        m_valid,
    input  wire         m_ready,
    output logic        m_reply_valid,
    output logic [2:0]  m_reply_kind,
    output logic [31:0] m_reply_addr,
    output logic [15:0] m_reply_seq,
    output logic        m_reply_arg,
    output logic        m_store_valid,
    output logic [22:0] m_store_offset,
    output logic [10:0] m_store_len,
    output logic        m_transfer_done,
    output logic        m_accept_seen,
    output logic [15:0] m_last_acked_seq
);

    swte_pkg::ctrl_cmd_t cmd;
    swte_pkg::ctrl_sts_t sts;

    swte_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    swte_dp #(
        .PEER_SLOTS (PEER_SLOTS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_source_addr    (s_source_addr),
        .s_magic_word     (s_magic_word),
        .s_packet_kind    (s_packet_kind),
        .s_seq_number     (s_seq_number),
        .s_header_arg     (s_header_arg),
        .s_total_length   (s_total_length),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_reply_valid    (m_reply_valid),
        .m_reply_kind     (m_reply_kind),
        .m_reply_addr     (m_reply_addr),
        .m_reply_seq      (m_reply_seq),
        .m_reply_arg      (m_reply_arg),
        .m_store_valid    (m_store_valid),
        .m_store_offset   (m_store_offset),
        .m_store_len      (m_store_len),
        .m_transfer_done  (m_transfer_done),
        .m_accept_seen    (m_accept_seen),
        .m_last_acked_seq (m_last_acked_seq)
    );

endmodule

`default_nettype wire

[rtl/swte_checker.sv]
`default_nettype none

module swte_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        m_valid,
    input wire        m_ready,
    input wire        m_reply_valid,
    input wire [2:0]  m_reply_kind,
    input wire [31:0] m_reply_addr,
    input wire [15:0] m_reply_seq,
    input wire        m_reply_arg,
    input wire        m_store_valid,
    input wire [10:0] m_store_len
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_no_reply_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_reply_valid |->
            m_reply_kind == 3'd0 && m_reply_addr == 32'd0 && m_reply_seq == 16'd0
            && !m_reply_arg)
        else $error("reply fields set without a reply");

    a_store_is_acked: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_store_valid |->
            m_reply_valid && m_reply_kind == swte_pkg::RK_ACK && m_store_len != 11'd0)
        else $error("buffer write without ack or with zero length");

endmodule

bind stop_wait_transfer_endpoint_core swte_checker u_swte_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_reply_valid (m_reply_valid),
    .m_reply_kind  (m_reply_kind),
    .m_reply_addr  (m_reply_addr),
    .m_reply_seq   (m_reply_seq),
    .m_reply_arg   (m_reply_arg),
    .m_store_valid (m_store_valid),
    .m_store_len   (m_store_len)
);

`default_nettype wire

[test/testbench.sv]
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PEER_SLOTS      = 16;
    localparam int POOL_SIZE       = 24;
    localparam int ITEMS_PER_PHASE = 187;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] magic;
        logic [7:0]  kind;
        logic [15:0] seq;
        logic [31:0] arg;
        logic [10:0] len;
    } packet_t;

    typedef struct packed {
        logic        reply_valid;
        logic [2:0]  reply_kind;
        logic [31:0] reply_addr;
        logic [15:0] reply_seq;
        logic        reply_arg;
        logic        store_valid;
        logic [22:0] store_offset;
        logic [10:0] store_len;
        logic        transfer_done;
        logic        accept_seen;
        logic [15:0] last_acked_seq;
    } response_t;

    logic        aclk;
    logic        aresetn        = 1'b0;
    logic        cfg_wr_en      = 1'b0;
    logic        cfg_index      = 1'b0;
    logic [22:0] cfg_wr_data    = '0;
    logic        s_valid        = 1'b0;
    wire         s_ready;
    logic [31:0] s_source_addr  = '0;
    logic [31:0] s_magic_word   = '0;
    logic [7:0]  s_packet_kind  = '0;
    logic [15:0] s_seq_number   = '0;
    logic [31:0] s_header_arg   = '0;
    logic [10:0] s_total_length = '0;
    wire         m_valid;
    logic        m_ready        = 1'b0;
    wire         m_reply_valid;
    wire  [2:0]  m_reply_kind;
    wire  [31:0] m_reply_addr;
    wire  [15:0] m_reply_seq;
    wire         m_reply_arg;
    wire         m_store_valid;
    wire  [22:0] m_store_offset;
    wire  [10:0] m_store_len;
    wire         m_transfer_done;
    wire         m_accept_seen;
    wire  [15:0] m_last_acked_seq;

    // endpoint state as predicted
    logic        cfg_role       = swte_pkg::ROLE_SENDER;
    logic [22:0] cfg_size_limit = swte_pkg::MAX_FILE_RESET;
    logic        rx_bound       = 1'b0;
    logic [31:0] rx_peer        = '0;
    logic [22:0] rx_file_len    = '0;
    logic [22:0] rx_filled      = '0;
    logic [15:0] rx_next_seq    = '0;
    logic        rx_done        = 1'b0;
    logic [31:0] tx_peers [PEER_SLOTS];
    int          tx_peer_cnt    = 0;
    logic        tx_accepted    = 1'b0;
    logic [15:0] tx_last_ack    = '0;

    response_t   pending_responses [$];
    logic [31:0] peer_pool [POOL_SIZE];
    bit          steady = 1'b0;
    bit          failed = 1'b0;

    stop_wait_transfer_endpoint_core #(
        .PEER_SLOTS(PEER_SLOTS)
    ) uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_source_addr   (s_source_addr),
        .s_magic_word    (s_magic_word),
        .s_packet_kind   (s_packet_kind),
        .s_seq_number    (s_seq_number),
        .s_header_arg    (s_header_arg),
        .s_total_length  (s_total_length),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_reply_valid   (m_reply_valid),
        .m_reply_kind    (m_reply_kind),
        .m_reply_addr    (m_reply_addr),
        .m_reply_seq     (m_reply_seq),
        .m_reply_arg     (m_reply_arg),
        .m_store_valid   (m_store_valid),
        .m_store_offset  (m_store_offset),
        .m_store_len     (m_store_len),
        .m_transfer_done (m_transfer_done),
        .m_accept_seen   (m_accept_seen),
        .m_last_acked_seq(m_last_acked_seq)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("** stop_wait_transfer_endpoint_core: FAILED **");
        $finish;
    end

    function automatic bit idle_now();
        return !steady && ($urandom_range(0, 99) < 11);
    endfunction

    function automatic packet_t make_packet(input logic [31:0] src, input logic [7:0] kind,
                                            input logic [15:0] seq, input logic [31:0] arg,
                                            input logic [10:0] len);
        packet_t p;
        p.src   = src;
        p.magic = swte_pkg::PROTO_MAGIC;
        p.kind  = kind;
        p.seq   = seq;
        p.arg   = arg;
        p.len   = len;
        return p;
    endfunction

    // Applies one packet to the predicted state and returns the result item it yields.
    function automatic response_t respond_to_packet(input packet_t p);
        response_t   r;
        logic [10:0] payload;
        logic [22:0] room;
        logic [22:0] take;
        logic        known;
        r = '0;
        if (p.len >= swte_pkg::HEADER_BYTES && p.magic == swte_pkg::PROTO_MAGIC) begin
            payload = p.len - swte_pkg::HEADER_BYTES;
            if (cfg_role == swte_pkg::ROLE_RECEIVER) begin
                case (p.kind)
                    swte_pkg::K_DISC: begin
                        r.reply_valid = 1'b1;
                        r.reply_kind  = swte_pkg::RK_ANN;
                        r.reply_addr  = p.src;
                    end
                    swte_pkg::K_OFFER: begin
                        if (!(rx_bound && p.src != rx_peer)
                            && p.arg <= {9'd0, cfg_size_limit}) begin
                            if (!rx_bound) begin
                                rx_file_len = p.arg[22:0];
                                rx_filled   = '0;
                                rx_next_seq = '0;
                                rx_peer     = p.src;
                                rx_bound    = 1'b1;
                            end
                            r.reply_valid = 1'b1;
                            r.reply_kind  = swte_pkg::RK_ACCEPT;
                            r.reply_addr  = p.src;
                        end
                    end
                    swte_pkg::K_DATA: begin
                        if (rx_bound && p.src == rx_peer) begin
                            if (p.seq == rx_next_seq) begin
                                room = (rx_file_len >= rx_filled) ? rx_file_len - rx_filled : '0;
                                take = ({12'd0, payload} < room) ? {12'd0, payload} : room;
                                if (take > swte_pkg::CHUNK_BYTES) begin
                                    take = swte_pkg::CHUNK_BYTES;
                                end
                                if (take != '0) begin
                                    r.store_valid  = 1'b1;
                                    r.store_offset = rx_filled;
                                    r.store_len    = take[10:0];
                                end
                                rx_filled   = rx_filled + take;
                                rx_next_seq = rx_next_seq + 16'd1;
                            end
                            r.reply_valid = 1'b1;
                            r.reply_kind  = swte_pkg::RK_ACK;
                            r.reply_addr  = p.src;
                            r.reply_seq   = p.seq;
                        end
                    end
                    swte_pkg::K_DONE: begin
                        if (rx_bound && p.src == rx_peer) begin
                            r.reply_valid = 1'b1;
                            r.reply_kind  = swte_pkg::RK_ACK;
                            r.reply_addr  = p.src;
                            r.reply_seq   = p.seq;
                            r.reply_arg   = 1'b1;
                            rx_done       = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end else begin
                case (p.kind)
                    swte_pkg::K_ANN: begin
                        known = 1'b0;
                        for (int i = 0; i < tx_peer_cnt; i++) begin
                            if (tx_peers[i] == p.src) begin
                                known = 1'b1;
                            end
                        end
                        if (!known && tx_peer_cnt < PEER_SLOTS) begin
                            tx_peers[tx_peer_cnt] = p.src;
                            tx_peer_cnt++;
                        end
                    end
                    swte_pkg::K_ACCEPT: tx_accepted = 1'b1;
                    swte_pkg::K_ACK:    tx_last_ack = p.seq;
                    default: ;
                endcase
            end
        end
        r.transfer_done  = rx_done;
        r.accept_seen    = tx_accepted;
        r.last_acked_seq = tx_last_ack;
        return r;
    endfunction

    task automatic write_register(input logic reg_index, input logic [22:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= reg_index;
        cfg_wr_data <= value;
        @(posedge aclk);
        if (reg_index == swte_pkg::REG_ROLE_MODE) begin
            cfg_role = value[0];
        end else begin
            cfg_size_limit = value;
        end
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Leaves valid high after acceptance; the next call or wait_for_idle takes it over.
    task automatic send_packet(input packet_t p);
        if (idle_now()) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while (idle_now()) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_source_addr  <= p.src;
        s_magic_word   <= p.magic;
        s_packet_kind  <= p.kind;
        s_seq_number   <= p.seq;
        s_header_arg   <= p.arg;
        s_total_length <= p.len;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_responses.push_back(respond_to_packet(p));
    endtask

    task automatic wait_for_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_responses.size() != 0) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failed = 1'b1;
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= !idle_now();
    end

    always @(posedge aclk) begin : check_results
        response_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_responses.size() == 0) begin
                $error("result item with no packet outstanding");
                failed = 1'b1;
            end else begin
                want = pending_responses.pop_front();
                check_field("reply_valid", want.reply_valid, m_reply_valid);
                check_field("reply_kind", want.reply_kind, m_reply_kind);
                check_field("reply_addr", want.reply_addr, m_reply_addr);
                check_field("reply_seq", want.reply_seq, m_reply_seq);
                check_field("reply_arg", want.reply_arg, m_reply_arg);
                check_field("store_valid", want.store_valid, m_store_valid);
                check_field("store_offset", want.store_offset, m_store_offset);
                check_field("store_len", want.store_len, m_store_len);
                check_field("transfer_done", want.transfer_done, m_transfer_done);
                check_field("accept_seen", want.accept_seen, m_accept_seen);
                check_field("last_acked_seq", want.last_acked_seq, m_last_acked_seq);
            end
        end
    end

    task automatic test_receiver_basics();
        logic [31:0] owner;
        logic [31:0] stranger;
        logic [22:0] size;
        packet_t     p;
        stranger = $urandom | 32'h1;
        owner    = ~stranger;
        size     = 23'($urandom_range(80000, 160000));
        write_register(swte_pkg::REG_ROLE_MODE, swte_pkg::ROLE_RECEIVER);
        write_register(swte_pkg::REG_MAX_FILE_BYTES, size);
        // nothing bound yet
        send_packet(make_packet(owner, swte_pkg::K_DATA, 16'd0, 32'd0, 11'd100));
        send_packet(make_packet(owner, swte_pkg::K_DONE, 16'd0, 32'd0, 11'd12));
        // short and bad-magic drops, then a discover from address zero
        send_packet(make_packet(stranger, swte_pkg::K_DISC, 16'd0, 32'd0, 11'd11));
        p = make_packet(stranger, swte_pkg::K_DISC, 16'd0, 32'd0, 11'd12);
        p.magic = swte_pkg::PROTO_MAGIC ^ 32'h8000_0001;
        send_packet(p);
        send_packet(make_packet(32'd0, swte_pkg::K_DISC, 16'd0, 32'd0, 11'd12));
        // size limit, then bind
        send_packet(make_packet(owner, swte_pkg::K_OFFER, 16'd0, {9'd0, size} + 32'd1,
                                11'd12));
        send_packet(make_packet(owner, swte_pkg::K_OFFER, 16'd0, 32'hFFFF_FFFF, 11'd12));
        send_packet(make_packet(owner, swte_pkg::K_OFFER, 16'hFFFF, {9'd0, size}, 11'd12));
        send_packet(make_packet(stranger, swte_pkg::K_OFFER, 16'd0, 32'd0, 11'd12));
        send_packet(make_packet(owner, swte_pkg::K_OFFER, 16'd0, {9'd0, size} + 32'd1,
                                11'd12));
        send_packet(make_packet(owner, swte_pkg::K_OFFER, 16'd0, 32'd0, 11'd12));
        // data: out of order, full chunk, oversized, empty, short, duplicate, foreign
        send_packet(make_packet(owner, swte_pkg::K_DATA, 16'd1, 32'd0, 11'd1036));
        send_packet(make_packet(owner, swte_pkg::K_DATA, 16'd0, 32'hFFFF_FFFF, 11'd1036));
        send_packet(make_packet(owner, swte_pkg::K_DATA, 16'd1, 32'd0, 11'd2047));
        send_packet(make_packet(owner, swte_pkg::K_DATA, 16'd2, 32'd0, 11'd12));
        send_packet(make_packet(owner, swte_pkg::K_DATA, 16'd3, 32'd0, 11'd11));
        send_packet(make_packet(owner, swte_pkg::K_DATA, 16'd2, 32'd0, 11'd500));
        send_packet(make_packet(stranger, swte_pkg::K_DATA, 16'd3, 32'd0, 11'd500));
        send_packet(make_packet(owner, swte_pkg::K_DONE, 16'hFFFF, 32'd0, 11'd12));
        send_packet(make_packet(owner, 8'd0, 16'd0, 32'd0, 11'd12));
        wait_for_idle();
    endtask

    task automatic test_sender_basics();
        write_register(swte_pkg::REG_ROLE_MODE, swte_pkg::ROLE_SENDER);
        send_packet(make_packet(peer_pool[0], swte_pkg::K_ANN, 16'd0, 32'd0, 11'd12));
        send_packet(make_packet(peer_pool[1], swte_pkg::K_ANN, 16'd0, 32'd0, 11'd12));
        send_packet(make_packet(peer_pool[0], swte_pkg::K_ANN, 16'd0, 32'd0, 11'd12));
        send_packet(make_packet(peer_pool[0], swte_pkg::K_ACCEPT, 16'd0, 32'd0, 11'd12));
        send_packet(make_packet(peer_pool[0], swte_pkg::K_ACK, 16'hFFFF, 32'd0, 11'd12));
        send_packet(make_packet(peer_pool[1], swte_pkg::K_ACK, 16'd0, 32'd0, 11'd12));
        send_packet(make_packet(peer_pool[2], swte_pkg::K_DISC, 16'd0, 32'd0, 11'd12));
        send_packet(make_packet(peer_pool[2], 8'd255, 16'd0, 32'd0, 11'd12));
        wait_for_idle();
    endtask

    task automatic test_random_traffic();
        logic        roles [6];
        logic [22:0] limits [6];
        packet_t     p;
        int          pick;
        roles  = '{swte_pkg::ROLE_RECEIVER, swte_pkg::ROLE_SENDER, swte_pkg::ROLE_RECEIVER,
                   swte_pkg::ROLE_SENDER, swte_pkg::ROLE_RECEIVER, swte_pkg::ROLE_RECEIVER};
        limits[0] = swte_pkg::MAX_FILE_RESET;
        limits[1] = '0;
        limits[2] = '0;
        limits[3] = 23'($urandom_range(1, 4194303));
        limits[4] = 23'($urandom_range(1, 200000));
        limits[5] = swte_pkg::MAX_FILE_RESET;
        for (int ph = 0; ph < 6; ph++) begin
            write_register(swte_pkg::REG_ROLE_MODE, roles[ph]);
            write_register(swte_pkg::REG_MAX_FILE_BYTES, limits[ph]);
            steady = (ph == 2);
            repeat (ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                p = make_packet(rx_peer, swte_pkg::K_DATA, rx_next_seq, $urandom,
                                11'($urandom_range(12, 1036)));
                if (cfg_role == swte_pkg::ROLE_RECEIVER) begin
                    if (pick < 10) begin
                        p.kind = swte_pkg::K_DISC;
                        p.src  = $urandom;
                    end else if (pick < 22) begin
                        p.kind = swte_pkg::K_OFFER;
                        if ($urandom_range(0, 3) == 0) begin
                            p.src = $urandom;
                        end
                        case ($urandom_range(0, 3))
                            0: p.arg = {9'd0, cfg_size_limit};
                            1: p.arg = {9'd0, cfg_size_limit} + 32'd1;
                            2: p.arg = $urandom_range(0, cfg_size_limit);
                            default: p.arg = $urandom;
                        endcase
                    end else if (pick < 82) begin
                        if ($urandom_range(0, 4) == 0) begin
                            p.seq = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                                : rx_next_seq - 16'd1;
                        end
                        case ($urandom_range(0, 9))
                            0: p.len = 11'd12;
                            1: p.len = 11'($urandom_range(1037, 2047));
                            2: p.src = $urandom;
                            default: ;
                        endcase
                    end else begin
                        p.kind = swte_pkg::K_DONE;
                        p.seq  = 16'($urandom);
                        if ($urandom_range(0, 3) == 0) begin
                            p.src = $urandom;
                        end
                    end
                end else begin
                    p.src = peer_pool[$urandom_range(0, POOL_SIZE - 1)];
                    p.seq = 16'($urandom);
                    if (pick < 50) begin
                        p.kind = swte_pkg::K_ANN;
                    end else if (pick < 60) begin
                        p.kind = swte_pkg::K_ACCEPT;
                    end else if (pick < 80) begin
                        p.kind = swte_pkg::K_ACK;
                    end else begin
                        p.kind = 8'($urandom_range(swte_pkg::K_DISC, swte_pkg::K_DONE));
                    end
                end
                if (pick >= 88) begin
                    p.src   = $urandom;
                    p.magic = $urandom_range(0, 1) ? swte_pkg::PROTO_MAGIC : $urandom;
                    p.kind  = 8'($urandom_range(0, 255));
                    p.seq   = 16'($urandom);
                    p.arg   = $urandom;
                    p.len   = 11'($urandom_range(0, 2047));
                end else if ($urandom_range(0, 39) == 0) begin
                    p.magic = swte_pkg::PROTO_MAGIC ^ (32'd1 << $urandom_range(0, 31));
                end else if ($urandom_range(0, 39) == 0) begin
                    p.len = 11'($urandom_range(0, 11));
                end
                send_packet(p);
            end
            wait_for_idle();
        end
        steady = 1'b0;
    endtask

    initial begin
        foreach (peer_pool[i]) begin
            peer_pool[i] = $urandom;
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_receiver_basics();
        test_sender_basics();
        test_random_traffic();
        repeat (40) @(posedge aclk);
        if (failed) begin
            $display("** stop_wait_transfer_endpoint_core: FAILED **");
        end else begin
            $display("** stop_wait_transfer_endpoint_core: PASSED **");
        end
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
rtl/swte_pkg.sv
rtl/swte_ctrl.sv
rtl/swte_dp.sv
rtl/stop_wait_transfer_endpoint_core.sv
rtl/swte_checker.sv
test/testbench.sv
